@@ hw/rtl/csv_decimal_integer_field_parser_defines.svh @@
// ---------------------------------------------------------------------------
// CSV decimal field parser: assertion macros
// Shared concurrent assertion shorthands for the parser checker.
// ---------------------------------------------------------------------------
`ifndef CSV_DECIMAL_INTEGER_FIELD_PARSER_DEFINES_SVH
`define CSV_DECIMAL_INTEGER_FIELD_PARSER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CSVP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("csvp: same-cycle check failed");

// next-cycle implication, disabled in reset
`define CSVP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("csvp: next-cycle check failed");

`endif

@@ hw/rtl/csvp_pkg.sv @@
// ---------------------------------------------------------------------------
// CSV decimal field parser package
// Widths, character codes and shared types.
// ---------------------------------------------------------------------------
`default_nettype none

package csvp_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned FIELD_W    = 32;
  // width of the digit magnitude; wraps modulo 2**VALUE_BITS
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned DIGIT_W    = 4;

  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned PUSH_W     = 2;

  typedef struct packed {
    logic signed [FIELD_W-1:0] field_value;
    logic                      comma_consumed;
    logic                      overflowed;
  } result_t;

  // up to two results per accepted byte, first goes out first
  typedef struct packed {
    logic [PUSH_W-1:0] count;
    result_t           first;
    result_t           second;
  } push_t;

endpackage

`default_nettype wire

@@ hw/rtl/csvp_stream_if.sv @@
// ---------------------------------------------------------------------------
// CSV decimal field parser stream interfaces
// Valid/ready channels for text bytes in and field results out.
// ---------------------------------------------------------------------------
`default_nettype none

interface csvp_in_if;
  import csvp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

interface csvp_out_if;
  import csvp_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] field_value;
  logic                      comma_consumed;
  logic                      overflowed;

  modport source (output valid, output field_value, output comma_consumed,
                  output overflowed, input ready);
  modport sink   (input valid, input field_value, input comma_consumed,
                  input overflowed, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/csvp_core.sv @@
// ---------------------------------------------------------------------------
// CSV decimal field parser core
// Per-byte field state machine and digit accumulator.
// ---------------------------------------------------------------------------
`default_nettype none

module csvp_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [csvp_pkg::BYTE_W-1:0]   text_byte_i,
  output csvp_pkg::push_t               push_o
);
  import csvp_pkg::*;

  typedef enum logic [2:0] {
    PH_FRESH  = 3'b001,
    PH_BLANK  = 3'b010,
    PH_DIGITS = 3'b100
  } phase_e;

  phase_e                  phase_q, phase_d;
  logic [VALUE_BITS-1:0]   acc_q, acc_d;
  logic                    neg_q, neg_d;
  logic                    ovf_q, ovf_d;

  logic                    is_digit;
  logic                    is_blank;
  logic                    is_comma;
  logic [DIGIT_W-1:0]      digit;
  logic [VALUE_BITS+3:0]   acc_next;
  logic                    step_ovf;
  logic [VALUE_BITS-1:0]   mag_sel;
  result_t                 field_res;
  result_t                 zero_res;

  assign is_digit = (text_byte_i >= CH_ZERO) && (text_byte_i <= CH_NINE);
  assign is_blank = (text_byte_i == CH_SPACE) || (text_byte_i == CH_TAB);
  assign is_comma = (text_byte_i == CH_COMMA);
  assign digit    = text_byte_i[DIGIT_W-1:0];

  // acc*10 + digit as (acc<<3) + (acc<<1) + digit; top bits flag a wrap
  assign acc_next = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
                  + {(VALUE_BITS)'(0), digit};
  assign step_ovf = |acc_next[VALUE_BITS+3:VALUE_BITS];

  assign mag_sel  = neg_q ? ((VALUE_BITS)'(0) - acc_q) : acc_q;

  always_comb begin
    field_res.field_value    = FIELD_W'($signed(mag_sel));
    field_res.comma_consumed = is_comma;
    field_res.overflowed     = ovf_q;
    zero_res                 = '0;
  end

  always_comb begin
    logic closing;
    logic was_blank;
    closing   = 1'b0;
    was_blank = 1'b0;

    phase_d       = phase_q;
    acc_d         = acc_q;
    neg_d         = neg_q;
    ovf_d         = ovf_q;
    push_o.count  = '0;
    push_o.first  = zero_res;
    push_o.second = zero_res;

    if (accept_i) begin
      unique case (phase_q)
        PH_DIGITS: closing   = 1'b1;
        PH_BLANK:  was_blank = 1'b1;
        default:   ;
      endcase

      if (closing && is_digit) begin
        acc_d = acc_next[VALUE_BITS-1:0];
        ovf_d = ovf_q | step_ovf;
      end else begin
        if (closing) begin
          push_o.first = field_res;
          push_o.count = PUSH_W'(1);
        end
        // fields are cleared whenever a field closes or a new one opens
        acc_d   = '0;
        neg_d   = 1'b0;
        ovf_d   = 1'b0;
        phase_d = PH_FRESH;
        priority if (closing && is_comma) begin
          phase_d = PH_FRESH;
        end else if (is_blank) begin
          phase_d = PH_BLANK;
        end else if (text_byte_i < CH_ZERO) begin
          // dropped sign byte
          neg_d   = (text_byte_i == CH_MINUS);
          phase_d = PH_DIGITS;
        end else if (is_digit) begin
          acc_d   = VALUE_BITS'(digit);
          phase_d = PH_DIGITS;
        end else begin
          // byte above '9' yields an empty field, two after blanks; after digits the closed field as well
          if (closing || was_blank) begin
            push_o.count = PUSH_W'(2);
          end else begin
            push_o.count = PUSH_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FRESH;
      acc_q   <= '0;
      neg_q   <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      neg_q   <= neg_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/csvp_result_fifo.sv @@
// ---------------------------------------------------------------------------
// CSV decimal field parser result queue
// Small queue taking up to two results a cycle and giving one.
// ---------------------------------------------------------------------------
`default_nettype none

module csvp_result_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  csvp_pkg::push_t     push_i,
  input  logic                pop_i,
  output logic                space_o,
  output logic                valid_o,
  output csvp_pkg::result_t   head_o
);
  import csvp_pkg::*;

  result_t            mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               do_pop;

  // room for a two-result transaction
  assign space_o = (count_q <= CNT_W'(FIFO_DEPTH - 2));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_W'(push_i.count);
    rd_ptr_d = rd_ptr_q + PTR_W'(do_pop);
    count_d  = count_q + CNT_W'(push_i.count) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != '0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == PUSH_W'(2)) begin
      mem_q[wr_ptr_q + PTR_W'(1)] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/csv_decimal_integer_field_parser.sv @@
// ---------------------------------------------------------------------------
// CSV decimal field parser, top level
// Streams text bytes in and emits one signed integer per numeric field.
// ---------------------------------------------------------------------------
// Usage:
//   in_i carries one ASCII byte per transaction; out_o carries one finished
//   field (value, comma flag, overflow flag) per transaction.
//   The parse state updates at the edge a byte is accepted; its results are
//   written to a four-entry queue, and a result written to an empty queue
//   shows on out_o in the next cycle. Throughput is one byte per cycle
//   while in_i.ready is high. A byte can close one field and open a second,
//   empty one, giving two results; the queue drains one per cycle while
//   out_o.ready is high, so in_i.ready is high while at most two entries
//   are queued. When the receiver stalls the queue fills and in_i.ready
//   drops; nothing is lost or repeated.
//   Reset (rst_ni low, asynchronous) returns the parser to field start,
//   clears the accumulator and flags and empties the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module csv_decimal_integer_field_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  csvp_in_if.sink       in_i,
  csvp_out_if.source    out_o
);
  import csvp_pkg::*;

  logic    accept;
  logic    space;
  logic    head_valid;
  push_t   push;
  result_t head;

  assign in_i.ready = space;
  assign accept     = in_i.valid && space;

  csvp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .text_byte_i (in_i.text_byte),
    .push_o      (push)
  );

  csvp_result_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_o.ready),
    .space_o (space),
    .valid_o (head_valid),
    .head_o  (head)
  );

  assign out_o.valid          = head_valid;
  assign out_o.field_value    = head.field_value;
  assign out_o.comma_consumed = head.comma_consumed;
  assign out_o.overflowed     = head.overflowed;

endmodule

`default_nettype wire

@@ hw/rtl/csvp_checker.sv @@
// ---------------------------------------------------------------------------
// CSV decimal field parser checker
// Port-level assertions, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "csv_decimal_integer_field_parser_defines.svh"

module csvp_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  logic signed [csvp_pkg::FIELD_W-1:0] out_field_value_i,
  input  logic                               out_comma_consumed_i,
  input  logic                               out_overflowed_i
);

  // a held result stays offered
  `CSVP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // a held result keeps its payload
  `CSVP_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_field_value_i) && $stable(out_comma_consumed_i) && $stable(out_overflowed_i))

  // results only appear after a byte transaction
  `CSVP_ASSERT_NEXT(a_no_spurious, clk_i, rst_ni, !out_valid_i && !(in_valid_i && in_ready_i), !out_valid_i)

  // an empty result queue always has room for the next byte
  `CSVP_ASSERT_NOW(a_ready_when_empty, clk_i, rst_ni, !out_valid_i, in_ready_i)

endmodule

bind csv_decimal_integer_field_parser csvp_checker u_csvp_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_valid_i           (in_i.valid),
  .in_ready_i           (in_i.ready),
  .out_valid_i          (out_o.valid),
  .out_ready_i          (out_o.ready),
  .out_field_value_i    (out_o.field_value),
  .out_comma_consumed_i (out_o.comma_consumed),
  .out_overflowed_i     (out_o.overflowed)
);

`default_nettype wire

@@ verif/csvp_field_checker.sv @@
// ---------------------------------------------------------------------------
// CSV decimal field parser: result checker
// Watches the byte and result channels, predicts each field from the bytes
// accepted and compares every result transaction against the oldest one due.
// ---------------------------------------------------------------------------
module csvp_field_checker
  import csvp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  csvp_in_if   text_mon,
  csvp_out_if  field_mon,
  output int   mismatch_count_o,
  output int   fields_due_o
);

  typedef enum logic [1:0] {
    AT_START,
    AFTER_BLANKS,
    IN_DIGITS
  } scan_phase_e;

  scan_phase_e            scan_phase;
  logic [VALUE_BITS-1:0]  magnitude;
  logic                   is_negative;
  logic                   has_wrapped;
  result_t                fields_due[$];

  task automatic report_mismatch(input string what, input longint want, input longint got);
    $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
    mismatch_count_o++;
  endtask

  task automatic restart_field();
    scan_phase  = AT_START;
    magnitude   = '0;
    is_negative = 1'b0;
    has_wrapped = 1'b0;
  endtask

  task automatic queue_field(input logic signed [FIELD_W-1:0] value, input logic comma,
                             input logic wrapped);
    result_t r;
    r.field_value    = value;
    r.comma_consumed = comma;
    r.overflowed     = wrapped;
    fields_due.push_back(r);
  endtask

  // signed value of the field so far, sign-extended or cut to the port width
  function automatic logic signed [FIELD_W-1:0] signed_field();
    logic [VALUE_BITS-1:0]         folded;
    logic signed [FIELD_W-1:0]     value;
    folded = is_negative ? -magnitude : magnitude;
    value  = $signed(folded);
    return value;
  endfunction

  task automatic scan_text_byte(input logic [BYTE_W-1:0] b);
    logic                  is_digit;
    logic [DIGIT_W-1:0]    digit;
    logic [VALUE_BITS+3:0] widened;
    is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    digit    = DIGIT_W'(b - CH_ZERO);

    if (scan_phase == IN_DIGITS) begin
      if (is_digit) begin
        widened = magnitude * 10 + digit;
        if (widened[VALUE_BITS+3:VALUE_BITS] != '0) has_wrapped = 1'b1;
        magnitude = widened[VALUE_BITS-1:0];
        return;
      end
      queue_field(signed_field(), b == CH_COMMA, has_wrapped);
      restart_field();
      if (b == CH_COMMA) return;
    end

    // terminator that was not a comma falls through as a fresh field start
    if (b == CH_SPACE || b == CH_TAB) begin
      scan_phase = AFTER_BLANKS;
    end else if (b < CH_ZERO) begin
      is_negative = (b == CH_MINUS);
      magnitude   = '0;
      has_wrapped = 1'b0;
      scan_phase  = IN_DIGITS;
    end else if (is_digit) begin
      magnitude   = VALUE_BITS'(digit);
      is_negative = 1'b0;
      has_wrapped = 1'b0;
      scan_phase  = IN_DIGITS;
    end else begin
      // byte above '9' opening a field: empty field, plus one for the blanks
      if (scan_phase == AFTER_BLANKS) queue_field('0, 1'b0, 1'b0);
      queue_field('0, 1'b0, 1'b0);
      restart_field();
    end
  endtask

  task automatic check_field();
    result_t want;
    if (fields_due.size() == 0) begin
      report_mismatch("result with nothing due, field_value", 0, field_mon.field_value);
      return;
    end
    want = fields_due.pop_front();
    if (field_mon.field_value !== want.field_value)
      report_mismatch("field_value", want.field_value, field_mon.field_value);
    if (field_mon.comma_consumed !== want.comma_consumed)
      report_mismatch("comma_consumed", want.comma_consumed, field_mon.comma_consumed);
    if (field_mon.overflowed !== want.overflowed)
      report_mismatch("overflowed", want.overflowed, field_mon.overflowed);
  endtask

  // a byte's results are registered in the queue before they are offered, so retire first
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_field();
      fields_due.delete();
    end else begin
      if (field_mon.valid && field_mon.ready) check_field();
      if (text_mon.valid && text_mon.ready) scan_text_byte(text_mon.text_byte);
    end
    fields_due_o = fields_due.size();
  end

endmodule

@@ verif/tb.sv @@
// ---------------------------------------------------------------------------
// CSV decimal field parser testbench
// Feeds directed corner-case text and then random comma-separated fields
// with random gaps on the byte side and random stalls on the result side,
// including one long hold-off that backs the parser up. Checking is done
// by the field checker alongside the parser.
// ---------------------------------------------------------------------------
module tb;
  import csvp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 500_000;
  localparam int unsigned TOTAL_BYTES  = 950;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned HOLD_FIELD   = 40;

  logic clk_i;
  logic rst_ni;
  int   mismatch_count;
  int   fields_due;
  int   bytes_sent;
  int   quiet_fields;
  bit   hold_pending;
  int   cycle_count;

  csvp_in_if  text_if ();
  csvp_out_if field_if ();

  csv_decimal_integer_field_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (text_if),
    .out_o  (field_if)
  );

  csvp_field_checker field_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .text_mon         (text_if),
    .field_mon        (field_if),
    .mismatch_count_o (mismatch_count),
    .fields_due_o     (fields_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // mostly back to back, often a short pause, now and then a long one
  function automatic int pick_idle();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet_fields > 0) return 0;
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // each pass starts on a falling edge and drives ready once
  initial begin
    int stall;
    field_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        field_if.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
      end else begin
        stall = pick_idle();
        if (stall == 0) begin
          field_if.ready <= 1'b1;
        end else begin
          field_if.ready <= 1'b0;
          repeat (stall - 1) @(negedge clk_i);
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // called on a falling edge, returns on the falling edge after the transaction
  task automatic send_text_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = pick_idle();
    if (gap > 0) begin
      text_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    text_if.valid     <= 1'b1;
    text_if.text_byte <= b;
    @(posedge clk_i);
    while (!text_if.ready) @(posedge clk_i);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_text_byte(s[i]);
  endtask

  task automatic send_random_field();
    int roll;
    int digits;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      // noise
      repeat ($urandom_range(1, 6)) send_text_byte(BYTE_W'($urandom_range(0, 255)));
      return;
    end
    if (roll < 12) begin
      // around the wrap point
      if ($urandom_range(0, 1)) send_text_byte(CH_MINUS);
      send_text($urandom_range(0, 1) ? "4294967295," : "4294967296,");
      return;
    end

    roll = $urandom_range(0, 99);
    if (roll < 25) begin
      repeat ($urandom_range(1, 2)) send_text_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    end

    roll = $urandom_range(0, 99);
    if (roll < 30)      send_text_byte(CH_MINUS);
    else if (roll < 36) send_text_byte(BYTE_W'($urandom_range(0, CH_ZERO - 1)));

    roll = $urandom_range(0, 99);
    if (roll < 4)       digits = 0;
    else if (roll < 14) digits = $urandom_range(10, 12);
    else                digits = $urandom_range(1, 5);
    repeat (digits) send_text_byte(CH_ZERO + BYTE_W'($urandom_range(0, 9)));

    roll = $urandom_range(0, 99);
    if (roll < 70)      send_text_byte(CH_COMMA);
    else if (roll < 80) send_text_byte(CH_SPACE);
    else if (roll < 88) send_text_byte(8'h0A);
    else                send_text_byte(BYTE_W'($urandom_range(CH_NINE + 1, 255)));
  endtask

  initial begin
    int field_idx;
    rst_ni            = 1'b0;
    text_if.valid     = 1'b0;
    text_if.text_byte = '0;
    hold_pending      = 1'b0;
    quiet_fields      = 0;
    bytes_sent        = 0;
    cycle_count       = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: minus zero, bad first byte, bad byte after blanks,
    // leading comma, sign with no digits, bare one ended by a low byte
    // that then opens a field which wraps
    send_text("-0,");
    send_text_byte(8'hFF);
    send_text(" \tA");
    send_text(",5,");
    send_text("-x");
    send_text("1");
    send_text_byte(8'h00);
    send_text("99999999999,");

    field_idx = 0;
    while (bytes_sent < TOTAL_BYTES) begin
      if (field_idx == HOLD_FIELD) begin
        hold_pending = 1'b1;
        quiet_fields = 60;
      end else if (quiet_fields == 0 && $urandom_range(0, 14) == 0) begin
        quiet_fields = $urandom_range(5, 20);
      end
      send_random_field();
      if (quiet_fields > 0) quiet_fields--;
      field_idx++;
    end
    text_if.valid <= 1'b0;

    while (fields_due != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
